// ===== hdl/aml_sleep_package_scanner_top_assert.svh =====
// ----------------------------------------------------------------------------
// aml sleep package scanner assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as disable
// ----------------------------------------------------------------------------
`ifndef AML_SLEEP_PACKAGE_SCANNER_TOP_ASSERT_SVH
`define AML_SLEEP_PACKAGE_SCANNER_TOP_ASSERT_SVH

// same-cycle implication
`define AML_SPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aml_sps assertion failed");

// next-cycle implication
`define AML_SPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aml_sps assertion failed");

`endif

// ===== hdl/aml_sps_pkg.sv =====
// ----------------------------------------------------------------------------
// aml_sps_pkg
// types and constants of the aml sleep package scanner
// ----------------------------------------------------------------------------
package aml_sps_pkg;

    localparam int MAX_BODY_BYTES = 1048576;
    localparam int POS_W          = $clog2(MAX_BODY_BYTES + 1);
    localparam int CAPTURE_DEPTH  = 6;
    localparam int CAP_IDX_W      = $clog2(CAPTURE_DEPTH);
    localparam int SINCE_W        = 7;

    localparam logic [39:0] PATTERN_HEAD = 40'h08_5F_53_35_5F;
    localparam logic [7:0]  PACKAGE_OP   = 8'h12;
    localparam logic [7:0]  BYTE_PREFIX  = 8'h0A;
    localparam logic [7:0]  LEN_LIMIT    = 8'h40;
    localparam logic [SINCE_W-1:0] SINCE_MAX = SINCE_W'(64);

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_NO_MATCH    = 4'd1,
        ST_MULTIPLE    = 4'd2,
        ST_NO_BODY     = 4'd3,
        ST_BAD_LENGTH  = 4'd4,
        ST_TOO_LONG    = 4'd5,
        ST_FEW         = 4'd6,
        ST_A_RANGE     = 4'd7,
        ST_A_CODING    = 4'd8,
        ST_B_RANGE     = 4'd9,
        ST_B_CODING    = 4'd10
    } status_t;

    typedef struct packed {
        logic [7:0] aml_byte;
        logic       last_byte;
    } aml_in_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] sleep_type_a;
        logic [7:0] sleep_type_b;
    } aml_res_t;

    typedef logic [7:0] cap_arr_t [CAPTURE_DEPTH];

endpackage

// ===== hdl/aml_sleep_package_scanner_top.sv =====
// ----------------------------------------------------------------------------
// aml_sleep_package_scanner_top
// scans an aml body for the _S5_ named package and decodes its sleep types
// ----------------------------------------------------------------------------
// One body byte is taken per cycle on the aml channel, and a result appears
// on the res channel in the cycle after the byte that carries last_byte is
// accepted. Every byte is handled by the combinational window compare,
// capture and decode logic, so the sustained rate is one byte per cycle; the
// aml channel stalls only while a finished result sits in the output
// register and res_ready is low. Bytes beyond MAX_BODY_BYTES are ignored but
// a final mark on them still closes the body. After each result all scan
// state returns to its reset value for the next body.
module aml_sleep_package_scanner_top
    import aml_sps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     aml_valid,
    output logic     aml_ready,
    input  aml_in_t  aml,
    output logic     res_valid,
    input  logic     res_ready,
    output aml_res_t res
);

    // scan state
    logic [39:0]        recent_reg, recent_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [1:0]         match_reg, match_next;
    logic [SINCE_W-1:0] since_reg, since_next;   // counted bytes since first match, saturating
    cap_arr_t           cap_reg, cap_next;

    // output register
    logic     res_valid_reg;
    aml_res_t res_reg;
    aml_res_t res_next;

    logic accept;
    logic counted;
    logic hit;

    assign aml_ready = !res_valid_reg || res_ready;
    assign accept    = aml_valid && aml_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // decode the captured package after the current byte
    function automatic aml_res_t decode(input logic [1:0] mc, input logic [SINCE_W-1:0] rs,
                                        input cap_arr_t c);
        aml_res_t         r;
        logic [SINCE_W-1:0] lim;
        logic             first_zero;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [SINCE_W-1:0] off;
        r   = '{status: ST_OK, sleep_type_a: 8'd0, sleep_type_b: 8'd0};
        lim = SINCE_W'(c[0]) + SINCE_W'(1);
        first_zero = (c[2] == 8'd0);
        b0  = first_zero ? c[3] : c[4];
        b1  = first_zero ? c[4] : c[5];
        off = first_zero ? SINCE_W'(3) : SINCE_W'(4);
        if (mc == 2'd0)
            r.status = ST_NO_MATCH;
        else if (mc >= 2'd2)
            r.status = ST_MULTIPLE;
        else if (rs == '0)
            r.status = ST_NO_BODY;
        else if (c[0] >= LEN_LIMIT)
            r.status = ST_BAD_LENGTH;
        else if (lim > rs)
            r.status = ST_TOO_LONG;
        else if (rs <= SINCE_W'(1) || c[1] < 8'd2)
            r.status = ST_FEW;
        else if (lim <= SINCE_W'(2) || (c[2] == BYTE_PREFIX && lim <= SINCE_W'(3)))
            r.status = ST_A_RANGE;
        else if (!first_zero && c[2] != BYTE_PREFIX)
            r.status = ST_A_CODING;
        else if (lim <= off || (b0 == BYTE_PREFIX && lim <= off + SINCE_W'(1)))
            r.status = ST_B_RANGE;
        else if (b0 != 8'd0 && b0 != BYTE_PREFIX)
            r.status = ST_B_CODING;
        else
        begin
            r.sleep_type_a = first_zero ? 8'd0 : c[3];
            r.sleep_type_b = (b0 == 8'd0) ? 8'd0 : b1;
        end
        return r;
    endfunction

    // next scan state for the byte on the input
    always_comb
    begin
        counted     = pos_reg < POS_W'(MAX_BODY_BYTES);
        hit         = counted && aml.aml_byte == PACKAGE_OP && recent_reg == PATTERN_HEAD;
        recent_next = recent_reg;
        pos_next    = pos_reg;
        match_next  = match_reg;
        since_next  = since_reg;
        cap_next    = cap_reg;
        if (counted)
        begin
            // capture uses the match count from before this byte
            if (match_reg != 2'd0)
            begin
                if (since_reg < SINCE_W'(CAPTURE_DEPTH))
                    cap_next[since_reg[CAP_IDX_W-1:0]] = aml.aml_byte;
                if (since_reg < SINCE_MAX)
                    since_next = since_reg + SINCE_W'(1);
            end
            if (hit)
            begin
                if (match_reg == 2'd0)
                begin
                    match_next = 2'd1;
                    since_next = '0;
                end
                else
                    match_next = 2'd2;
            end
            recent_next = {recent_reg[31:0], aml.aml_byte};
            pos_next    = pos_reg + POS_W'(1);
        end
        res_next = decode(match_next, since_next, cap_next);
    end

    // scan state registers, cleared after each body
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            pos_reg    <= '0;
            match_reg  <= '0;
            since_reg  <= '0;
            for (int i = 0; i < CAPTURE_DEPTH; i++)
                cap_reg[i] <= '0;
        end
        else if (accept)
        begin
            if (aml.last_byte)
            begin
                recent_reg <= '0;
                pos_reg    <= '0;
                match_reg  <= '0;
                since_reg  <= '0;
                for (int i = 0; i < CAPTURE_DEPTH; i++)
                    cap_reg[i] <= '0;
            end
            else
            begin
                recent_reg <= recent_next;
                pos_reg    <= pos_next;
                match_reg  <= match_next;
                since_reg  <= since_next;
                cap_reg    <= cap_next;
            end
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept && aml.last_byte)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && aml.last_byte)
            res_reg <= res_next;
    end

endmodule

// ===== hdl/aml_sps_checker.sv =====
// ----------------------------------------------------------------------------
// aml_sps_checker
// port-level checks of the aml sleep package scanner, bound to the top level
// ----------------------------------------------------------------------------
`include "aml_sleep_package_scanner_top_assert.svh"

module aml_sps_checker
    import aml_sps_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     aml_valid,
    input logic     aml_ready,
    input aml_in_t  aml,
    input logic     res_valid,
    input logic     res_ready,
    input aml_res_t res
);

    logic aml_last_xact;

    assign aml_last_xact = aml_valid && aml_ready && aml.last_byte;

    // a stalled result transaction holds
    `AML_SPS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

    // the final byte of a body always yields a result
    `AML_SPS_ASSERT_NEXT(a_last_gives_res, aml_last_xact, res_valid)

    // no result appears without a final byte
    `AML_SPS_ASSERT_NEXT(a_no_spurious_res, !res_valid && !aml_last_xact, !res_valid)

    // failing status carries zero sleep types
    `AML_SPS_ASSERT_NOW(a_zero_on_error, res_valid && res.status != ST_OK,
        res.sleep_type_a == 8'd0 && res.sleep_type_b == 8'd0)

endmodule

bind aml_sleep_package_scanner_top aml_sps_checker u_aml_sps_checker (.*);
